/* hdl/bfa_pkg.sv */
package bfa_pkg;

  localparam int unsigned MAP_BITS   = 32768;
  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned MAP_WORDS  = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WADDR_W    = $clog2(MAP_WORDS);
  localparam int unsigned LOG_W      = $clog2(WORD_BITS);
  localparam int unsigned SLOT_W     = 15;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned SLOT_SPAN  = 32768;
  localparam int unsigned BOUND_CAP  = (MAP_BITS < SLOT_SPAN) ? MAP_BITS : SLOT_SPAN;
  localparam int unsigned BIT_W      = $clog2(MAP_WORDS * WORD_BITS) + 1;
  localparam int unsigned CMP_W      = (BIT_W > LIMIT_W + 1) ? BIT_W : LIMIT_W + 1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(SLOT_SPAN);

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_MARK  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] index;
  } cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              found;
  } result_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK,
    ST_SCAN
  } state_e;

  // Position of the single set bit in a one-hot word.
  function automatic logic [LOG_W-1:0] onehot_pos(input logic [WORD_BITS-1:0] oh);
    logic [LOG_W-1:0] pos;
    pos = '0;
    for (int unsigned i = 0; i < WORD_BITS; i++) begin
      if (oh[i]) begin
        pos = pos | LOG_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

/* hdl/bfa_ram.sv */
module bfa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/bitmap_first_free_allocator_unit.sv */
// First-fit bitmap allocator.
// Command channel: cmd_i is transferred at a clock edge with start_i high and
// busy_o low. kind ALLOC takes the lowest clear bit below the search limit and
// sets it; kind MARK sets the bit at cmd_i.index.
// Result channel: done_o is high for exactly one cycle with res_o valid; the
// receiver cannot stall it. Every command gives exactly one result.
// Config channel: cfg_data_i is written to search_limit when cfg_valid_i and
// cfg_ready_o are high. cfg_ready_o is always high; write only while idle.
// Result path (command transfer to done_o):
//   MARK: done_o follows ST_MARK (one read-modify-write of the bitmap word).
//   ALLOC with a zero limit, or MARK out of range: done_o registered from ST_IDLE.
//   ALLOC: done_o follows the last ST_SCAN step; one step per word read until
//   a free bit or the limit, 1 to 512 words. The single bitmap RAM read port,
//   one 64-bit word per cycle, sets the scan pace.
// busy_o falls with done_o, so the next command can be taken in the result
// cycle. After reset the block holds busy_o high while it clears the bitmap
// RAM one word per cycle; config writes are taken then.
module bitmap_first_free_allocator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  bfa_pkg::cmd_t                  cmd_i,
  output logic                           done_o,
  output bfa_pkg::result_t               res_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bfa_pkg::LIMIT_W-1:0]    cfg_data_i
);

  localparam int unsigned WADDR_W = bfa_pkg::WADDR_W;
  localparam int unsigned WORD_W  = bfa_pkg::WORD_BITS;
  localparam int unsigned LOG_W   = bfa_pkg::LOG_W;
  localparam int unsigned CMP_W   = bfa_pkg::CMP_W;
  localparam int unsigned SLOT_W  = bfa_pkg::SLOT_W;

  bfa_pkg::state_e              state_q, state_d;
  logic [WADDR_W-1:0]           addr_q, addr_d;
  logic [SLOT_W-1:0]            index_q, index_d;
  logic [bfa_pkg::LIMIT_W-1:0]  limit_q;
  logic                         done_q, done_d;
  bfa_pkg::result_t             res_q, res_d;

  logic                         ram_we;
  logic [WADDR_W-1:0]           ram_waddr;
  logic [WORD_W-1:0]            ram_wdata;
  logic [WADDR_W-1:0]           ram_raddr;
  logic [WORD_W-1:0]            ram_rdata;

  logic [CMP_W-1:0]             bound;
  logic [CMP_W-1:0]             limit_ext;
  logic [CMP_W-1:0]             cmd_idx_ext;
  logic [CMP_W-1:0]             cmd_word_ext;
  logic [CMP_W-1:0]             mark_word_ext;
  logic [WORD_W-1:0]            avail;
  logic [WORD_W-1:0]            lowest;
  logic [CMP_W-1:0]             base;
  logic [CMP_W-1:0]             hit;
  logic [WADDR_W:0]             nxt;
  logic [CMP_W-1:0]             nxt_base;

  bfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (bfa_pkg::MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign limit_ext     = CMP_W'(limit_q);
  assign bound         = (limit_ext > CMP_W'(bfa_pkg::BOUND_CAP)) ?
                         CMP_W'(bfa_pkg::BOUND_CAP) : limit_ext;
  assign cmd_idx_ext   = CMP_W'(cmd_i.index);
  assign cmd_word_ext  = cmd_idx_ext >> LOG_W;
  assign mark_word_ext = CMP_W'(index_q) >> LOG_W;

  assign avail    = ~ram_rdata;
  assign lowest   = avail & (~avail + WORD_W'(1));
  assign base     = CMP_W'(addr_q) << LOG_W;
  assign hit      = base + CMP_W'(bfa_pkg::onehot_pos(lowest));
  assign nxt      = (WADDR_W + 1)'(addr_q) + (WADDR_W + 1)'(1);
  assign nxt_base = CMP_W'(nxt) << LOG_W;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfa_pkg::ST_CLEAR;
      addr_q  <= '0;
      limit_q <= bfa_pkg::LIMIT_RESET;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    index_q <= index_d;
    res_q   <= res_d;
  end

  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    index_d   = index_q;
    done_d    = 1'b0;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '0;
    ram_raddr = addr_q;
    case (state_q)
      bfa_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        if (addr_q == WADDR_W'(bfa_pkg::MAP_WORDS - 1)) begin
          addr_d  = '0;
          state_d = bfa_pkg::ST_IDLE;
        end else begin
          addr_d = addr_q + WADDR_W'(1);
        end
      end
      bfa_pkg::ST_IDLE: begin
        if (start_i) begin
          if (cmd_i.kind == bfa_pkg::KIND_MARK) begin
            if (cmd_idx_ext < CMP_W'(bfa_pkg::MAP_BITS)) begin
              ram_raddr = cmd_word_ext[WADDR_W-1:0];
              index_d   = cmd_i.index;
              state_d   = bfa_pkg::ST_MARK;
            end else begin
              done_d = 1'b1;
              res_d  = '0;
            end
          end else if (bound == '0) begin
            done_d = 1'b1;
            res_d  = '0;
          end else begin
            ram_raddr = '0;
            addr_d    = '0;
            state_d   = bfa_pkg::ST_SCAN;
          end
        end
      end
      bfa_pkg::ST_MARK: begin
        ram_we      = 1'b1;
        ram_waddr   = mark_word_ext[WADDR_W-1:0];
        ram_wdata   = ram_rdata | (WORD_W'(1) << index_q[LOG_W-1:0]);
        done_d      = 1'b1;
        res_d.slot  = index_q;
        res_d.found = 1'b1;
        state_d     = bfa_pkg::ST_IDLE;
      end
      bfa_pkg::ST_SCAN: begin
        if (|avail) begin
          done_d  = 1'b1;
          state_d = bfa_pkg::ST_IDLE;
          if (hit < bound) begin
            ram_we      = 1'b1;
            ram_wdata   = ram_rdata | lowest;
            res_d.slot  = hit[SLOT_W-1:0];
            res_d.found = 1'b1;
          end else begin
            res_d = '0;
          end
        end else if (nxt_base >= bound) begin
          done_d  = 1'b1;
          res_d   = '0;
          state_d = bfa_pkg::ST_IDLE;
        end else begin
          ram_raddr = nxt[WADDR_W-1:0];
          addr_d    = nxt[WADDR_W-1:0];
        end
      end
      default: begin
        state_d = bfa_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o      = (state_q != bfa_pkg::ST_IDLE);
  assign done_o      = done_q;
  assign res_o       = res_q;
  assign cfg_ready_o = 1'b1;

endmodule

/* hdl/bfa_checker.sv */
module bfa_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input bfa_pkg::cmd_t    cmd_i,
  input logic             done_o,
  input bfa_pkg::result_t res_o
);

  // A transferred command either keeps the unit busy or answers at once.
  a_cmd_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("command transfer left unit idle without result");

  // The result cycle frees the command channel.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  // Failed results carry slot zero.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.found) |-> (res_o.slot == '0))
    else $error("failed result with nonzero slot");

  // An in-range mark echoes its index in its result.
  a_mark_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (cmd_i.kind == bfa_pkg::KIND_MARK) &&
     (32'(cmd_i.index) < 32'(bfa_pkg::MAP_BITS)))
    |-> ##2 (done_o && res_o.found && (res_o.slot == $past(cmd_i.index, 2))))
    else $error("mark result wrong");

endmodule

bind bitmap_first_free_allocator_unit bfa_checker u_bfa_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .cmd_i   (cmd_i),
  .done_o  (done_o),
  .res_o   (res_o)
);

/* sim/testbench.sv */
module testbench;
  import bfa_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned TAIL_CYCLES  = 520;
  localparam int unsigned RANDOM_ITEMS = 600;

  typedef enum logic [1:0] {
    OP_CMD,
    OP_LIMIT,
    OP_DRAIN
  } op_kind_e;

  typedef struct {
    op_kind_e           what;
    cmd_t               cmd;
    logic [LIMIT_W-1:0] limit;
    int unsigned        gap;
  } pending_op_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  cmd_t               cmd_i = '0;
  logic               done_o;
  result_t            res_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [LIMIT_W-1:0] cfg_data_i = '0;

  bit [WORD_BITS-1:0] usage_model [MAP_WORDS];
  logic [LIMIT_W-1:0] limit_model = LIMIT_RESET;

  pending_op_t pending_ops [$];
  result_t     results_due [$];
  int unsigned gap_left = 0;
  int          in_flight = 0;
  int unsigned failures = 0;
  int unsigned cycles = 0;
  int unsigned items_queued = 0;
  bit          no_idle = 1'b0;

  bitmap_first_free_allocator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .cmd_i       (cmd_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // First-fit search below the saturated limit; marks set the given bit.
  function automatic result_t apply_command(input cmd_t c);
    result_t     r;
    int unsigned bound;
    int unsigned at;
    bit          searching;
    r = '0;
    if (c.kind == KIND_MARK) begin
      if (int'(c.index) < MAP_BITS) begin
        usage_model[c.index / WORD_BITS][c.index % WORD_BITS] = 1'b1;
        r.slot  = c.index;
        r.found = 1'b1;
      end
    end else begin
      bound = 32'(limit_model);
      if (bound > BOUND_CAP) bound = BOUND_CAP;
      searching = 1'b1;
      at = 0;
      for (int unsigned w = 0; w < MAP_WORDS; w++) begin
        if (searching && w * WORD_BITS >= bound) searching = 1'b0;
        if (searching && usage_model[w] != '1) begin
          searching = 1'b0;
          for (int p = WORD_BITS - 1; p >= 0; p--) begin
            if (!usage_model[w][p]) at = w * WORD_BITS + p;
          end
          if (at < bound) begin
            usage_model[w][at % WORD_BITS] = 1'b1;
            r.slot  = SLOT_W'(at);
            r.found = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (no_idle || sel < 60) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic void add_cmd(input logic kind, input logic [SLOT_W-1:0] index);
    pending_op_t op;
    op.what      = OP_CMD;
    op.cmd.kind  = kind;
    op.cmd.index = index;
    op.limit     = '0;
    op.gap       = pick_gap();
    pending_ops.push_back(op);
    items_queued++;
  endfunction

  function automatic void add_drain();
    pending_op_t op;
    op.what  = OP_DRAIN;
    op.cmd   = '0;
    op.limit = '0;
    op.gap   = 0;
    pending_ops.push_back(op);
  endfunction

  // Limit writes only go out once the block has returned every result.
  function automatic void add_limit(input logic [LIMIT_W-1:0] value);
    pending_op_t op;
    add_drain();
    op.what  = OP_LIMIT;
    op.cmd   = '0;
    op.limit = value;
    op.gap   = 0;
    pending_ops.push_back(op);
  endfunction

  // Driver: one nonblocking assignment per signal per edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o && in_flight > 0) in_flight--;
      if (start_i && !busy_o) begin
        results_due.push_back(apply_command(cmd_i));
        in_flight++;
      end
      if (cfg_valid_i && cfg_ready_o) limit_model = cfg_data_i;

      if (start_i && busy_o) begin
      end else if (cfg_valid_i && !cfg_ready_o) begin
      end else if (gap_left > 0) begin
        gap_left--;
        start_i     <= 1'b0;
        cfg_valid_i <= 1'b0;
      end else if (pending_ops.size() == 0) begin
        start_i     <= 1'b0;
        cfg_valid_i <= 1'b0;
      end else begin
        case (pending_ops[0].what)
          OP_CMD: begin
            start_i     <= 1'b1;
            cmd_i       <= pending_ops[0].cmd;
            cfg_valid_i <= 1'b0;
            gap_left     = pending_ops[0].gap;
            pending_ops.pop_front();
          end
          OP_LIMIT: begin
            start_i     <= 1'b0;
            cfg_valid_i <= 1'b1;
            cfg_data_i  <= pending_ops[0].limit;
            pending_ops.pop_front();
          end
          default: begin
            start_i     <= 1'b0;
            cfg_valid_i <= 1'b0;
            if (in_flight == 0) pending_ops.pop_front();
          end
        endcase
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      if (results_due.size() == 0) begin
        $display("%0t: result with none due: slot=%0d found=%0b",
                 $time, res_o.slot, res_o.found);
        failures++;
      end else begin
        want = results_due.pop_front();
        if (res_o.slot !== want.slot) begin
          $display("%0t: slot mismatch: expected %0d, actual %0d",
                   $time, want.slot, res_o.slot);
          failures++;
        end
        if (res_o.found !== want.found) begin
          $display("%0t: found mismatch: expected %0b, actual %0b",
                   $time, want.found, res_o.found);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    int unsigned        n;
    int unsigned        sel;
    int unsigned        base;
    int unsigned        len;
    int unsigned        random_start;
    logic [LIMIT_W-1:0] lim;

    // directed: zero limit, saturating limit, remarks, limit inside a word
    add_limit('0);
    add_cmd(KIND_ALLOC, '1);
    add_limit('1);
    add_cmd(KIND_ALLOC, '0);
    add_cmd(KIND_ALLOC, 15'h2AAA);
    add_cmd(KIND_MARK, 15'd2);
    add_cmd(KIND_MARK, 15'd2);
    add_cmd(KIND_ALLOC, 15'h5555);
    add_cmd(KIND_MARK, '1);
    add_cmd(KIND_MARK, '0);
    add_cmd(KIND_MARK, 15'd64);
    add_cmd(KIND_ALLOC, '0);
    add_limit(16'd1);
    add_cmd(KIND_ALLOC, '0);
    add_limit(16'd6);
    add_cmd(KIND_ALLOC, '0);
    add_cmd(KIND_ALLOC, '0);
    add_limit(16'd65);
    add_cmd(KIND_ALLOC, '1);
    add_limit(LIMIT_RESET);
    add_cmd(KIND_ALLOC, '0);
    add_cmd(KIND_MARK, 15'h5555);
    add_cmd(KIND_MARK, 15'h2AAA);
    add_cmd(KIND_ALLOC, '1);

    random_start = items_queued;
    while (items_queued - random_start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: lim = '0;
        1: lim = '1;
        2: lim = LIMIT_RESET;
        3: lim = 16'd32767;
        4: lim = LIMIT_W'($urandom_range(1, 64));
        5, 6, 7: lim = LIMIT_W'($urandom_range(1, 800));
        default: lim = LIMIT_W'($urandom);
      endcase
      add_limit(lim);
      no_idle = ($urandom_range(0, 3) == 0);
      n = $urandom_range(15, 50);
      repeat (n) begin
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
          add_cmd(KIND_ALLOC, SLOT_W'($urandom));
        end else if (sel < 80) begin
          if ($urandom_range(0, 1)) add_cmd(KIND_MARK, SLOT_W'($urandom));
          else add_cmd(KIND_MARK, SLOT_W'($urandom_range(0, 1023)));
        end else if (sel < 92) begin
          // run of marks over low words so later allocations scan further
          base = $urandom_range(0, 15) * WORD_BITS + $urandom_range(0, 3);
          len  = $urandom_range(4, 70);
          for (int unsigned k = 0; k < len; k++) add_cmd(KIND_MARK, SLOT_W'(base + k));
        end else begin
          add_drain();
        end
      end
    end

    do @(negedge clk_i);
    while (pending_ops.size() != 0 || start_i || cfg_valid_i || results_due.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
